>>> rtl/gsd_pkg.sv
// ============================================================================
// gsd_pkg: shared types, constants and functions of the group spike detector
// Sizes of the sample row, the per-group state, the internal queues and the
// register map, plus the channel magnitude and queue pointer functions.
// ============================================================================
package gsd_pkg;

    // Block dimensions
    localparam int GROUPS             = 16;
    localparam int CHANNELS_PER_GROUP = 4;
    localparam int SAMPLE_BITS        = 16;

    // Fixed field widths of the ports
    localparam int CHAN_FIELDS = 4;
    localparam int CHAN_W      = 16;
    localparam int GRP_W       = 4;
    localparam int TIME_W      = 63;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_MAG_W   = 16;

    // Derived widths
    localparam int NCH       = (CHANNELS_PER_GROUP < CHAN_FIELDS) ?
                               CHANNELS_PER_GROUP : CHAN_FIELDS;
    localparam int MAG_W     = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
    localparam int GRP_IDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    // Depth of the classified-row queue and of the result queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DETECT_THRESHOLD = 2'd0,
        REG_RETURN_THRESHOLD = 2'd1,
        REG_RETURN_COUNT     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] detect_threshold;
        logic [CFG_W-1:0] return_threshold;
        logic [CFG_W-1:0] return_count;
    } cfg_t;

    typedef logic [CHAN_FIELDS-1:0][CHAN_W-1:0] chan_vec_t;

    // One classified sample row, handed from the front end to the back end
    typedef struct packed {
        logic                 in_range;
        logic [GRP_IDX_W-1:0] grp;
        logic                 above;
        logic                 below;
        logic [MAG_W-1:0]     peak;
        logic [TIME_W-1:0]    ts;
    } class_t;

    // One finished detection
    typedef struct packed {
        logic [GRP_W-1:0]     grp;
        logic [TIME_W-1:0]    peak_time;
        logic [OUT_MAG_W-1:0] peak_magnitude;
    } event_t;

    // Absolute value of the low SAMPLE_BITS bits of a raw channel word,
    // read as two's complement.
    function automatic logic [MAG_W-1:0] magnitude_of(input logic [CHAN_W-1:0] raw);
        logic [MAG_W-1:0]       ext;
        logic [SAMPLE_BITS-1:0] v;
        logic [SAMPLE_BITS-1:0] neg;
        ext = MAG_W'(raw);
        v   = ext[SAMPLE_BITS-1:0];
        neg = ~v + SAMPLE_BITS'(1);
        if (v[SAMPLE_BITS-1])
            return MAG_W'(neg);
        return MAG_W'(v);
    endfunction

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] ptr);
        if (ptr == QPTR_W'(QUEUE_DEPTH - 1))
            return '0;
        return ptr + QPTR_W'(1);
    endfunction

endpackage

>>> rtl/gsd_front.sv
// ============================================================================
// gsd_front: row classifier and classified-row queue
// Computes channel magnitudes, threshold flags and the row peak, and queues
// the classified row for the back end.
// ============================================================================
module gsd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [gsd_pkg::GRP_W-1:0]     grp,
    input  logic [gsd_pkg::TIME_W-1:0]    timestamp,
    input  gsd_pkg::chan_vec_t            chan,
    input  gsd_pkg::cfg_t                 cfg,
    output logic                          q_valid,
    output gsd_pkg::class_t               q_head,
    input  logic                          q_pop
);
    import gsd_pkg::*;

    class_t              cls;
    logic [MAG_W-1:0]    mag [NCH];
    logic                accept;

    class_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;

    // Classification of the incoming row
    always_comb
    begin
        cls          = '0;
        cls.in_range = (int'(grp) < GROUPS);
        cls.grp      = GRP_IDX_W'(grp);
        cls.ts       = timestamp;
        cls.below    = 1'b1;
        for (int c = 0; c < NCH; c++)
        begin
            mag[c] = magnitude_of(chan[c]);
            if (mag[c] > MAG_W'(cfg.detect_threshold))
                cls.above = 1'b1;
            if (!(mag[c] < MAG_W'(cfg.return_threshold)))
                cls.below = 1'b0;
            if (mag[c] > cls.peak)
                cls.peak = mag[c];
        end
    end

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign accept  = push && !full;
    assign q_valid = (count_reg != '0);
    assign q_head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = accept ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = q_pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (accept && !q_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!accept && q_pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            entry_reg[wr_ptr_reg] <= cls;
    end

endmodule

>>> rtl/gsd_back.sv
// ============================================================================
// gsd_back: per-group detection state and result queue
// Applies one classified row per cycle to its group's state, while the
// result queue is not full, and queues a result when a detection ends.
// ============================================================================
module gsd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gsd_pkg::CFG_W-1:0]     return_count,
    input  logic                          q_valid,
    input  gsd_pkg::class_t               q_head,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output gsd_pkg::event_t               evt
);
    import gsd_pkg::*;

    // Per-group state
    logic                 active_reg    [GROUPS];
    logic [CFG_W-1:0]     quiet_reg     [GROUPS];
    logic [MAG_W-1:0]     best_mag_reg  [GROUPS];
    logic [TIME_W-1:0]    best_time_reg [GROUPS];

    logic                 cur_active;
    logic [CFG_W-1:0]     cur_quiet;
    logic [MAG_W-1:0]     cur_best;
    logic [TIME_W-1:0]    cur_time;
    logic [CFG_W-1:0]     quiet_inc;
    logic                 new_peak;

    logic                 st_we;
    logic                 active_next;
    logic [CFG_W-1:0]     quiet_next;
    logic [MAG_W-1:0]     best_mag_next;
    logic [TIME_W-1:0]    best_time_next;
    logic                 emit;
    event_t               new_evt;

    // Result queue
    event_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg,  count_next;
    logic                 out_pop;

    assign q_pop      = q_valid && (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign cur_active = active_reg[q_head.grp];
    assign cur_quiet  = quiet_reg[q_head.grp];
    assign cur_best   = best_mag_reg[q_head.grp];
    assign cur_time   = best_time_reg[q_head.grp];
    assign quiet_inc  = (cur_quiet == '1) ? cur_quiet : cur_quiet + CFG_W'(1);
    assign new_peak   = q_head.peak > cur_best;

    always_comb
    begin
        st_we          = 1'b0;
        emit           = 1'b0;
        active_next    = cur_active;
        quiet_next     = cur_quiet;
        best_mag_next  = new_peak ? q_head.peak : cur_best;
        best_time_next = new_peak ? q_head.ts   : cur_time;

        new_evt                = '0;
        new_evt.grp            = GRP_W'(q_head.grp);
        new_evt.peak_time      = best_time_next;
        new_evt.peak_magnitude = OUT_MAG_W'(best_mag_next);

        if (q_pop && q_head.in_range)
        begin
            if (!cur_active)
            begin
                if (q_head.above)
                begin
                    st_we          = 1'b1;
                    active_next    = 1'b1;
                    best_mag_next  = q_head.peak;
                    best_time_next = q_head.ts;
                end
            end
            else
            begin
                st_we = 1'b1;
                if (!q_head.below)
                    quiet_next = '0;
                else if (quiet_inc >= return_count)
                begin
                    emit          = 1'b1;
                    active_next   = 1'b0;
                    quiet_next    = '0;
                    best_mag_next = '0;
                end
                else
                    quiet_next = quiet_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                active_reg[g] <= 1'b0;
                quiet_reg[g]  <= '0;
            end
        end
        else if (st_we)
        begin
            active_reg[q_head.grp] <= active_next;
            quiet_reg[q_head.grp]  <= quiet_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            best_mag_reg[q_head.grp]  <= best_mag_next;
            best_time_reg[q_head.grp] <= best_time_next;
        end
    end

    // Result queue control
    assign empty   = (count_reg == '0);
    assign out_pop = pop && !empty;
    assign evt     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = emit    ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = out_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (emit && !out_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!emit && out_pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            entry_reg[wr_ptr_reg] <= new_evt;
    end

endmodule

>>> rtl/group_spike_detector.sv
// ============================================================================
// group_spike_detector: threshold and hysteresis spike detector
// Per-group detection of spikes in a stream of multichannel sample rows,
// reporting the peak magnitude and its timestamp when each detection ends.
// ============================================================================
// Usage:
// The input channel behaves like the write side of a queue. A sample row
// (group, timestamp and four channel samples) is taken as a transaction at
// every rising edge with push high and full low. The result channel behaves
// like the read side of a queue: while empty is low, the oldest finished
// detection is on event_group, peak_time and peak_magnitude, and it is taken
// at a rising edge with pop high.
// A row is classified in the cycle it is accepted and queued; the back end
// then applies it to its group's state and registers the result of the row
// ending a detection in the result queue, which feeds the result ports.
// One row per cycle is sustained while the result queue is not full: the
// rate is set by the single read-modify-write of the per-group state in the
// back end. Two-entry queues sit between the classifier and the back end and
// in front of the result ports, so with a stalled receiver full rises once
// two results are waiting and two more rows are queued behind them.
// Reset puts every group idle, empties both queues and loads the thresholds
// with 1000 and 500 and the return count with 8. Registers are written
// through wr_en, wr_index and wr_data and should only change while no row
// is in flight.
// ============================================================================
module group_spike_detector (
    input  logic                              clk,
    input  logic                              rst_n,

    // Register write port
    input  logic                              wr_en,
    input  logic [gsd_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [gsd_pkg::CFG_W-1:0]         wr_data,

    // Sample rows
    input  logic                              push,
    output logic                              full,
    input  logic [gsd_pkg::GRP_W-1:0]         group,
    input  logic [gsd_pkg::TIME_W-1:0]        timestamp,
    input  logic signed [gsd_pkg::CHAN_W-1:0] chan_0,
    input  logic signed [gsd_pkg::CHAN_W-1:0] chan_1,
    input  logic signed [gsd_pkg::CHAN_W-1:0] chan_2,
    input  logic signed [gsd_pkg::CHAN_W-1:0] chan_3,

    // Detection results
    output logic                              empty,
    input  logic                              pop,
    output logic [gsd_pkg::GRP_W-1:0]         event_group,
    output logic [gsd_pkg::TIME_W-1:0]        peak_time,
    output logic [gsd_pkg::OUT_MAG_W-1:0]     peak_magnitude
);
    import gsd_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    chan_vec_t  chan;
    logic       q_valid;
    logic       q_pop;
    class_t     q_head;
    event_t     evt;

    // Register file. An index outside the map is ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_DETECT_THRESHOLD: cfg_next.detect_threshold = wr_data;
                REG_RETURN_THRESHOLD: cfg_next.return_threshold = wr_data;
                REG_RETURN_COUNT:     cfg_next.return_count     = wr_data;
                default:              cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detect_threshold <= CFG_W'(1000);
            cfg_reg.return_threshold <= CFG_W'(500);
            cfg_reg.return_count     <= CFG_W'(8);
        end
        else
            cfg_reg <= cfg_next;
    end

    assign chan[0] = chan_0;
    assign chan[1] = chan_1;
    assign chan[2] = chan_2;
    assign chan[3] = chan_3;

    // The front end classifies each row against the thresholds and queues it.
    gsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .grp       (group),
        .timestamp (timestamp),
        .chan      (chan),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop)
    );

    // The back end updates the group state and queues finished detections.
    gsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .return_count (cfg_reg.return_count),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .evt          (evt)
    );

    assign event_group    = evt.grp;
    assign peak_time      = evt.peak_time;
    assign peak_magnitude = evt.peak_magnitude;

endmodule

>>> rtl/gsd_checker.sv
// ============================================================================
// gsd_checker: port-level assertions for the group spike detector
// Watches the queue-style channels of the top level over time.
// ============================================================================
module gsd_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              full,
    input  logic                              empty,
    input  logic                              pop,
    input  logic [gsd_pkg::GRP_W-1:0]         event_group,
    input  logic [gsd_pkg::TIME_W-1:0]        peak_time,
    input  logic [gsd_pkg::OUT_MAG_W-1:0]     peak_magnitude
);
    import gsd_pkg::*;

    // A waiting result that is not taken stays on the ports unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(event_group) &&
                              $stable(peak_time) && $stable(peak_magnitude)))
        else $error("result changed or vanished while stalled");

    // A detection only starts above the threshold, so its peak is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (peak_magnitude != '0))
        else $error("result with zero peak magnitude");

    // The input queue can only fill up on an accepted transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without an accepted transaction");

    // The result queue can only drain through a taken transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(empty) |-> $past(pop))
        else $error("result queue drained without a pop");

endmodule

bind group_spike_detector gsd_checker u_gsd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .event_group    (event_group),
    .peak_time      (peak_time),
    .peak_magnitude (peak_magnitude)
);
